// ===== hdl/mi3_pkg.sv =====
`default_nettype none

package mi3_pkg;

  // Element format and fixed port widths.
  localparam int unsigned DATA_WIDTH = 32;
  localparam int unsigned FRAC_BITS  = 16;
  localparam int unsigned THR_WIDTH  = 31;
  localparam logic [THR_WIDTH-1:0] THR_RESET = THR_WIDTH'(1);

  // Exact intermediate widths.
  localparam int unsigned PROD_W = 2 * DATA_WIDTH;
  localparam int unsigned ADJ_W  = PROD_W + 1;
  localparam int unsigned HI_W   = ADJ_W - DATA_WIDTH;
  localparam int unsigned PP_W   = 2 * DATA_WIDTH + 1;
  localparam int unsigned TERM_W = DATA_WIDTH + ADJ_W;
  localparam int unsigned DET_W  = TERM_W + 2;
  localparam int unsigned NUM_W  = ADJ_W + 2 * FRAC_BITS;

  // Divider geometry: one quotient bit per stage.
  localparam int unsigned QB     = DATA_WIDTH + 1;
  localparam int unsigned REM_W  = DET_W + QB;

  // Pipeline depth.
  localparam int unsigned PRE_STAGES = 8;
  localparam int unsigned DIV_STAGES = QB + 3;
  localparam int unsigned LATENCY    = PRE_STAGES + DIV_STAGES;

  // Operand pairs of the eighteen 2x2 products; adjugate k = p[2k] - p[2k+1].
  localparam int unsigned MUL_L [18] = '{4, 5, 2, 1, 1, 2, 5, 3, 0, 2, 2, 0, 3, 4, 1, 0, 0, 1};
  localparam int unsigned MUL_R [18] = '{8, 7, 7, 8, 5, 4, 6, 8, 8, 6, 3, 5, 7, 6, 6, 7, 4, 3};

  // Cofactors used for the expansion along row 0.
  localparam int unsigned COF_IDX [3] = '{0, 3, 6};

  // Per-lane control that travels alongside the divider data.
  typedef struct packed {
    logic neg;
    logic sing;
  } mi3_ctl_t;

endpackage

`default_nettype wire

// ===== hdl/mi3_div.sv =====
`default_nettype none

module mi3_div (
  input  wire                                  clk_i,
  input  wire                                  en_i,
  input  wire  logic [mi3_pkg::NUM_W-1:0]      num_i,
  input  wire  logic [mi3_pkg::DET_W-1:0]      den_i,
  input  wire  mi3_pkg::mi3_ctl_t              ctl_i,
  output logic signed [mi3_pkg::DATA_WIDTH-1:0] quo_o,
  output logic                                 sat_o
);
  import mi3_pkg::*;

  localparam logic [QB:0] LIM_NEG = (QB+1)'(1) << (DATA_WIDTH - 1);
  localparam logic [QB:0] LIM_POS = LIM_NEG - (QB+1)'(1);

  logic [REM_W-1:0] rem_q [QB+1];
  logic [DET_W-1:0] den_q [QB+1];
  logic [QB-1:0]    quo_q [QB+1];
  mi3_ctl_t         ctl_q [QB+1];
  logic             big_q [QB+1];

  logic [REM_W-1:0] diff [QB+1];
  logic             take [QB+1];

  logic [QB:0]      qr_q;
  mi3_ctl_t         ctl_r_q;
  logic             big_r_q;
  logic             rnd;

  logic signed [DATA_WIDTH-1:0] quo_q_out;
  logic                         sat_q;

  // Trial subtraction of the shifted divisor, one quotient bit per stage.
  always_comb begin
    diff[0] = '0;
    take[0] = 1'b0;
    for (int s = 1; s <= QB; s++) begin
      diff[s] = rem_q[s-1] - (REM_W'(den_q[s-1]) << (QB - s));
      take[s] = !big_q[s-1] && (rem_q[s-1] >= (REM_W'(den_q[s-1]) << (QB - s)));
    end
  end

  // Round half away from zero: the remainder is below the divisor here.
  assign rnd = {rem_q[QB][DET_W-1:0], 1'b0} >= {1'b0, den_q[QB]};

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      // Overflow check: a quotient beyond QB bits saturates unless the matrix is singular.
      rem_q[0] <= REM_W'(num_i);
      den_q[0] <= den_i;
      quo_q[0] <= '0;
      ctl_q[0] <= ctl_i;
      big_q[0] <= REM_W'(num_i) >= (REM_W'(den_i) << QB);

      for (int s = 1; s <= QB; s++) begin
        rem_q[s] <= take[s] ? diff[s] : rem_q[s-1];
        den_q[s] <= den_q[s-1];
        quo_q[s] <= quo_q[s-1] | (take[s] ? (QB'(1) << (QB - s)) : QB'(0));
        ctl_q[s] <= ctl_q[s-1];
        big_q[s] <= big_q[s-1];
      end

      qr_q    <= {1'b0, quo_q[QB]} + (QB+1)'(rnd);
      ctl_r_q <= ctl_q[QB];
      big_r_q <= big_q[QB];

      // Saturate, apply sign, and force zero for a singular matrix.
      if (ctl_r_q.sing) begin
        quo_q_out <= '0;
        sat_q     <= 1'b0;
      end else if (ctl_r_q.neg) begin
        if (big_r_q || qr_q > LIM_NEG) begin
          quo_q_out <= -$signed(LIM_NEG[DATA_WIDTH-1:0]);
          sat_q     <= 1'b1;
        end else begin
          quo_q_out <= -$signed(qr_q[DATA_WIDTH-1:0]);
          sat_q     <= 1'b0;
        end
      end else begin
        if (big_r_q || qr_q > LIM_POS) begin
          quo_q_out <= $signed(LIM_POS[DATA_WIDTH-1:0]);
          sat_q     <= 1'b1;
        end else begin
          quo_q_out <= $signed(qr_q[DATA_WIDTH-1:0]);
          sat_q     <= 1'b0;
        end
      end
    end
  end

  assign quo_o = quo_q_out;
  assign sat_o = sat_q;

endmodule

`default_nettype wire

// ===== hdl/matrix3x3_inverse_top.sv =====
// Throughput: one matrix per cycle while the output is not stalled; the depth is set by the
// nine dividers, one quotient bit per stage, behind eight stages of products, adjugate and
// determinant.
// A stalled output beat freezes the whole pipeline, which then stalls the input.
// Reset clears every valid bit and sets the singular threshold to 1.
`default_nettype none

module matrix3x3_inverse_top (
  input  wire                                   clk_i,
  input  wire                                   rst_ni,
  input  wire                                   cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  wire  logic [mi3_pkg::THR_WIDTH-1:0]   cfg_data_i,
  input  wire                                   in_valid_i,
  output logic                                  in_stall_o,
  input  wire  logic [mi3_pkg::DATA_WIDTH-1:0]  a_00_i,
  input  wire  logic [mi3_pkg::DATA_WIDTH-1:0]  a_01_i,
  input  wire  logic [mi3_pkg::DATA_WIDTH-1:0]  a_02_i,
  input  wire  logic [mi3_pkg::DATA_WIDTH-1:0]  a_10_i,
  input  wire  logic [mi3_pkg::DATA_WIDTH-1:0]  a_11_i,
  input  wire  logic [mi3_pkg::DATA_WIDTH-1:0]  a_12_i,
  input  wire  logic [mi3_pkg::DATA_WIDTH-1:0]  a_20_i,
  input  wire  logic [mi3_pkg::DATA_WIDTH-1:0]  a_21_i,
  input  wire  logic [mi3_pkg::DATA_WIDTH-1:0]  a_22_i,
  output logic                                  out_valid_o,
  input  wire                                   out_stall_i,
  output logic [mi3_pkg::DATA_WIDTH-1:0]        inv_00_o,
  output logic [mi3_pkg::DATA_WIDTH-1:0]        inv_01_o,
  output logic [mi3_pkg::DATA_WIDTH-1:0]        inv_02_o,
  output logic [mi3_pkg::DATA_WIDTH-1:0]        inv_10_o,
  output logic [mi3_pkg::DATA_WIDTH-1:0]        inv_11_o,
  output logic [mi3_pkg::DATA_WIDTH-1:0]        inv_12_o,
  output logic [mi3_pkg::DATA_WIDTH-1:0]        inv_20_o,
  output logic [mi3_pkg::DATA_WIDTH-1:0]        inv_21_o,
  output logic [mi3_pkg::DATA_WIDTH-1:0]        inv_22_o,
  output logic                                  singular_o,
  output logic                                  saturated_o
);
  import mi3_pkg::*;

  logic [THR_WIDTH-1:0] thr_q;
  logic [LATENCY-1:0]   vld_q;
  logic                 adv;

  logic signed [DATA_WIDTH-1:0] a_in [9];
  logic signed [DATA_WIDTH-1:0] a_q  [9];
  logic signed [PROD_W-1:0]     prod_q [18];
  logic signed [DATA_WIDTH-1:0] cof2_q [3];
  logic signed [DATA_WIDTH-1:0] cof3_q [3];
  logic signed [ADJ_W-1:0]      adj3_q [9];
  logic signed [ADJ_W-1:0]      adj4_q [9];
  logic signed [ADJ_W-1:0]      adj5_q [9];
  logic signed [ADJ_W-1:0]      adj6_q [9];
  logic signed [PP_W-1:0]       pl_q [3];
  logic signed [PP_W-1:0]       ph_q [3];
  logic signed [TERM_W-1:0]     term_q [3];
  logic signed [DET_W-1:0]      det_q;
  logic [DET_W-1:0]             mag_q;
  logic                         zero_q;
  logic [ADJ_W-1:0]             adjabs_q [9];
  logic                         neg_q [9];
  logic [NUM_W-1:0]             num_q [9];
  mi3_ctl_t                     ctl8_q [9];
  logic [DET_W-1:0]             den8_q;
  logic                         sing8;

  logic signed [DATA_WIDTH-1:0] quo [9];
  logic [8:0]                   sat;

  assign a_in[0] = a_00_i;
  assign a_in[1] = a_01_i;
  assign a_in[2] = a_02_i;
  assign a_in[3] = a_10_i;
  assign a_in[4] = a_11_i;
  assign a_in[5] = a_12_i;
  assign a_in[6] = a_20_i;
  assign a_in[7] = a_21_i;
  assign a_in[8] = a_22_i;

  // The pipeline moves unless a finished beat waits at the output.
  assign adv         = !(vld_q[LATENCY-1] && out_stall_i);
  assign in_stall_o  = !adv;
  assign cfg_ready_o = 1'b1;

  // Threshold register and valid bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= THR_RESET;
      vld_q <= '0;
    end else begin
      if (cfg_valid_i) begin
        thr_q <= cfg_data_i;
      end
      if (adv) begin
        vld_q <= {vld_q[LATENCY-2:0], in_valid_i};
      end
    end
  end

  // Singular test against the threshold scaled to the determinant format.
  assign sing8 = zero_q ||
                 (mag_q < DET_W'({thr_q, {(2 * FRAC_BITS){1'b0}}}));

  // Front stages: products, adjugate, determinant, magnitudes.
  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int i = 0; i < 9; i++) begin
        a_q[i] <= a_in[i];
      end

      for (int p = 0; p < 18; p++) begin
        prod_q[p] <= PROD_W'(a_q[MUL_L[p]]) * PROD_W'(a_q[MUL_R[p]]);
      end
      for (int j = 0; j < 3; j++) begin
        cof2_q[j] <= a_q[j];
      end

      for (int k = 0; k < 9; k++) begin
        adj3_q[k] <= ADJ_W'(prod_q[2*k]) - ADJ_W'(prod_q[2*k+1]);
      end
      cof3_q <= cof2_q;

      // Split each cofactor into an unsigned low word and a signed high part.
      for (int j = 0; j < 3; j++) begin
        pl_q[j] <= PP_W'(cof3_q[j]) *
                   $signed({1'b0, adj3_q[COF_IDX[j]][DATA_WIDTH-1:0]});
        ph_q[j] <= PP_W'(cof3_q[j]) *
                   PP_W'($signed(adj3_q[COF_IDX[j]][ADJ_W-1:DATA_WIDTH]));
      end
      adj4_q <= adj3_q;

      for (int j = 0; j < 3; j++) begin
        term_q[j] <= (TERM_W'(ph_q[j]) <<< DATA_WIDTH) + TERM_W'(pl_q[j]);
      end
      adj5_q <= adj4_q;

      det_q  <= DET_W'(term_q[0]) + DET_W'(term_q[1]) + DET_W'(term_q[2]);
      adj6_q <= adj5_q;

      mag_q  <= det_q[DET_W-1] ? DET_W'(-det_q) : DET_W'(det_q);
      zero_q <= (det_q == '0);
      for (int k = 0; k < 9; k++) begin
        adjabs_q[k] <= adj6_q[k][ADJ_W-1] ? ADJ_W'(-adj6_q[k]) : ADJ_W'(adj6_q[k]);
        neg_q[k]    <= adj6_q[k][ADJ_W-1] ^ det_q[DET_W-1];
      end

      den8_q <= mag_q;
      for (int k = 0; k < 9; k++) begin
        num_q[k]       <= {adjabs_q[k], {(2 * FRAC_BITS){1'b0}}};
        ctl8_q[k].neg  <= neg_q[k];
        ctl8_q[k].sing <= sing8;
      end
    end
  end

  // Nine divider lanes, one per inverse entry.
  for (genvar k = 0; k < 9; k++) begin : g_lane
    mi3_div u_div (
      .clk_i (clk_i),
      .en_i  (adv),
      .num_i (num_q[k]),
      .den_i (den8_q),
      .ctl_i (ctl8_q[k]),
      .quo_o (quo[k]),
      .sat_o (sat[k])
    );
  end

  // Singular flag rides in every lane; take it from lane 0 through a delay line.
  logic [DIV_STAGES-1:0] sing_dly_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      sing_dly_q <= {sing_dly_q[DIV_STAGES-2:0], ctl8_q[0].sing};
    end
  end

  assign out_valid_o = vld_q[LATENCY-1];
  assign inv_00_o    = quo[0];
  assign inv_01_o    = quo[1];
  assign inv_02_o    = quo[2];
  assign inv_10_o    = quo[3];
  assign inv_11_o    = quo[4];
  assign inv_12_o    = quo[5];
  assign inv_20_o    = quo[6];
  assign inv_21_o    = quo[7];
  assign inv_22_o    = quo[8];
  assign singular_o  = sing_dly_q[DIV_STAGES-1];
  assign saturated_o = |sat;

  // A singular result carries zero entries and no saturation; the diagonal and two upper entries are checked.
  a_sing_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && singular_o |-> !saturated_o && inv_00_o == '0 && inv_11_o == '0 &&
      inv_22_o == '0 && inv_01_o == '0 && inv_12_o == '0)
    else $error("singular result with nonzero entries");

  // The input is only held off while a finished beat waits.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without an output stall");

  // A frozen pipeline keeps its output beat valid in the next cycle.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |=> out_valid_o)
    else $error("output beat lost while stalled");

endmodule

`default_nettype wire

// ===== tb/sv/matrix3x3_inverse_checker.sv =====
`default_nettype none

module matrix3x3_inverse_checker (
  input  wire                                  clk_i,
  input  wire                                  rst_ni,
  input  wire                                  cfg_valid_i,
  input  wire                                  cfg_ready_i,
  input  wire  [mi3_pkg::THR_WIDTH-1:0]        cfg_data_i,
  input  wire                                  in_valid_i,
  input  wire                                  in_stall_i,
  input  wire  [9*mi3_pkg::DATA_WIDTH-1:0]     mat_i,
  input  wire                                  out_valid_i,
  input  wire                                  out_stall_i,
  input  wire  [9*mi3_pkg::DATA_WIDTH-1:0]     inv_i,
  input  wire                                  singular_i,
  input  wire                                  saturated_i,
  output int                                   errors_o,
  output int                                   pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  import mi3_pkg::*;

  localparam int W = DATA_WIDTH;
  localparam int F = FRAC_BITS;

  // One predicted result beat: nine entries packed row-major plus the flags.
  typedef struct packed {
    logic [9*W-1:0] inv;
    logic           singular;
    logic           saturated;
  } inverse_t;

  inverse_t         inverse_q[$];
  logic [THR_WIDTH-1:0] threshold;

  // Exact adjugate inverse with half-away rounding and saturation.
  function automatic inverse_t invert(logic [9*W-1:0] mat, logic [THR_WIDTH-1:0] thr);
    logic signed [255:0] a[9];
    logic signed [255:0] adj[9];
    logic signed [255:0] det, mag, num, q, r;
    logic signed [255:0] lim_hi, lim_lo, v;
    inverse_t res;
    res = '0;
    for (int i = 0; i < 9; i++) a[i] = 256'(signed'(mat[i*W +: W]));
    adj[0] = a[4]*a[8] - a[5]*a[7];
    adj[1] = a[2]*a[7] - a[1]*a[8];
    adj[2] = a[1]*a[5] - a[2]*a[4];
    adj[3] = a[5]*a[6] - a[3]*a[8];
    adj[4] = a[0]*a[8] - a[2]*a[6];
    adj[5] = a[2]*a[3] - a[0]*a[5];
    adj[6] = a[3]*a[7] - a[4]*a[6];
    adj[7] = a[1]*a[6] - a[0]*a[7];
    adj[8] = a[0]*a[4] - a[1]*a[3];
    det = a[0]*adj[0] + a[1]*adj[3] + a[2]*adj[6];
    mag = det < 0 ? -det : det;
    if (det == 0 || mag < (256'(thr) <<< (2*F))) begin
      res.singular = 1'b1;
      return res;
    end
    lim_hi = (256'sd1 <<< (W-1)) - 1;
    lim_lo = -(256'sd1 <<< (W-1));
    for (int i = 0; i < 9; i++) begin
      num = (adj[i] < 0 ? -adj[i] : adj[i]) <<< (2*F);
      q = num / mag;
      r = num % mag;
      if (2*r >= mag) q = q + 1;
      v = ((adj[i] < 0) != (det < 0)) ? -q : q;
      if (v > lim_hi) begin v = lim_hi; res.saturated = 1'b1; end
      if (v < lim_lo) begin v = lim_lo; res.saturated = 1'b1; end
      res.inv[i*W +: W] = v[W-1:0];
    end
    return res;
  endfunction

  assign pending_o = inverse_q.size();

  // Track the register, queue predictions, and compare result beats.
  always @(posedge clk_i or negedge rst_ni) begin
    inverse_t want;
    if (!rst_ni) begin
      threshold <= THR_RESET;
      errors_o  <= 0;
      inverse_q.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_i) threshold <= cfg_data_i;
      if (in_valid_i && !in_stall_i) inverse_q.push_back(invert(mat_i, threshold));
      if (out_valid_i && !out_stall_i) begin
        if (inverse_q.size() == 0) begin
          errors_o <= errors_o + 1;
          if (errors_o < 10) $display("Unexpected result beat at %0t", $realtime);
        end else begin
          want = inverse_q.pop_front();
          if (want.inv != inv_i || want.singular != singular_i
              || want.saturated != saturated_i) begin
            errors_o <= errors_o + 1;
            if (errors_o < 10)
              $display("Mismatch at %0t: exp inv=%h sing=%b sat=%b got inv=%h sing=%b sat=%b",
                       $realtime, want.inv, want.singular, want.saturated,
                       inv_i, singular_i, saturated_i);
          end
        end
      end
    end
  end

endmodule

`default_nettype wire

// ===== tb/sv/tb.sv =====
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import mi3_pkg::*;

  localparam int W = DATA_WIDTH;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [THR_WIDTH-1:0] cfg_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [9*W-1:0]       mat = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [9*W-1:0]       inv;
  logic                 singular, saturated;
  int                   errors, pending;
  bit                   calm = 1'b0;
  int                   hold_cycles = 0;

  always #4 clk = ~clk;

  matrix3x3_inverse_top i_dut (
    .clk_i(clk), .rst_ni(rst_n),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready), .cfg_data_i(cfg_data),
    .in_valid_i(in_valid), .in_stall_o(in_stall),
    .a_00_i(mat[0*W +: W]), .a_01_i(mat[1*W +: W]), .a_02_i(mat[2*W +: W]),
    .a_10_i(mat[3*W +: W]), .a_11_i(mat[4*W +: W]), .a_12_i(mat[5*W +: W]),
    .a_20_i(mat[6*W +: W]), .a_21_i(mat[7*W +: W]), .a_22_i(mat[8*W +: W]),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .inv_00_o(inv[0*W +: W]), .inv_01_o(inv[1*W +: W]), .inv_02_o(inv[2*W +: W]),
    .inv_10_o(inv[3*W +: W]), .inv_11_o(inv[4*W +: W]), .inv_12_o(inv[5*W +: W]),
    .inv_20_o(inv[6*W +: W]), .inv_21_o(inv[7*W +: W]), .inv_22_o(inv[8*W +: W]),
    .singular_o(singular), .saturated_o(saturated)
  );

  matrix3x3_inverse_checker i_checker (
    .clk_i(clk), .rst_ni(rst_n),
    .cfg_valid_i(cfg_valid), .cfg_ready_i(cfg_ready), .cfg_data_i(cfg_data),
    .in_valid_i(in_valid), .in_stall_i(in_stall), .mat_i(mat),
    .out_valid_i(out_valid), .out_stall_i(out_stall), .inv_i(inv),
    .singular_i(singular), .saturated_i(saturated),
    .errors_o(errors), .pending_o(pending)
  );

  // Receiver stalls: random, quiet during the calm stretch, solid during a hold.
  always @(posedge clk) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_stall   <= 1'b1;
    end else begin
      out_stall <= !calm && ($urandom_range(99) < 32);
    end
  end

  // Random element: mostly small values, some extremes and full-range noise.
  function automatic logic [W-1:0] rand_elem();
    case ($urandom_range(9))
      0:       return $urandom();
      1:       return {1'b1, {(W-1){1'b0}}};
      2:       return {1'b0, {(W-1){1'b1}}};
      3:       return W'($urandom_range(3));
      default: return W'(signed'($urandom_range(8 << 16)) - (4 << 16));
    endcase
  endfunction

  function automatic logic [9*W-1:0] rand_matrix();
    logic [9*W-1:0] m;
    int kind;
    kind = $urandom_range(9);
    for (int i = 0; i < 9; i++) m[i*W +: W] = rand_elem();
    // Some matrices with two equal rows are singular on purpose.
    if (kind == 0) m[3*W +: 3*W] = m[0 +: 3*W];
    // Some diagonal matrices with tiny entries exercise saturation.
    if (kind == 1)
      for (int i = 0; i < 9; i++) m[i*W +: W] = (i % 4 == 0) ? W'($urandom_range(40)) : '0;
    return m;
  endfunction

  // Send one matrix beat, with random idles first if may_idle is set and not calm.
  task automatic send_matrix(logic [9*W-1:0] m, bit may_idle);
    while (may_idle && !calm && $urandom_range(99) < 32) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    mat      <= m;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Drain every result, then write the threshold with the pipeline empty.
  task automatic write_threshold(logic [THR_WIDTH-1:0] v);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [9*W-1:0] diag(logic [W-1:0] d);
    logic [9*W-1:0] m;
    m = '0;
    m[0 +: W] = d; m[4*W +: W] = d; m[8*W +: W] = d;
    return m;
  endfunction

  localparam logic [W-1:0] ONE = W'(1 << FRAC_BITS);
  localparam logic [W-1:0] MAXV = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] MINV = {1'b1, {(W-1){1'b0}}};

  initial begin
    logic [9*W-1:0] m;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: identity, zero, extremes, tiny determinant, saturation, sign mixes.
    send_matrix(diag(ONE), 1'b0);
    send_matrix('0, 1'b0);
    send_matrix(diag(MAXV), 1'b0);
    send_matrix(diag(MINV), 1'b0);
    send_matrix(diag(W'(1)), 1'b0);
    send_matrix(diag(W'(2)), 1'b0);
    send_matrix(diag(W'(-signed'(ONE))), 1'b0);
    send_matrix({9{MAXV}}, 1'b0);
    send_matrix({9{MINV}}, 1'b0);
    send_matrix({9{32'hFFFF_FFFF}}, 1'b0);
    m = diag(ONE); m[1*W +: W] = MINV; m[5*W +: W] = MAXV;
    send_matrix(m, 1'b0);
    m = diag(W'(3 << 15)); m[6*W +: W] = W'(-(5 << 16));
    send_matrix(m, 1'b0);
    m = diag(W'(256)); m[4*W +: W] = W'(-256);
    send_matrix(m, 1'b0);

    // Threshold sweep with a zero threshold, the largest one and 1 << 16.
    write_threshold('0);
    send_matrix('0, 1'b0);
    send_matrix(diag(W'(1)), 1'b0);
    write_threshold({THR_WIDTH{1'b1}});
    send_matrix(diag(MAXV), 1'b0);
    send_matrix(diag(ONE), 1'b0);
    write_threshold(THR_WIDTH'(1 << 16));
    send_matrix(diag(ONE), 1'b0);
    send_matrix(diag(W'(ONE - 1)), 1'b0);

    // Random phases, one threshold per phase.
    for (int phase = 0; phase < 7; phase++) begin
      case (phase)
        0: write_threshold(THR_RESET);
        1: write_threshold('0);
        2: write_threshold(THR_WIDTH'($urandom_range(1 << 20)));
        3: write_threshold(THR_WIDTH'($urandom()));
        4: write_threshold({THR_WIDTH{1'b1}});
        default: write_threshold(THR_WIDTH'($urandom_range(1 << 16)));
      endcase
      calm = (phase == 5);
      if (phase == 2) hold_cycles <= 200;
      for (int n = 0; n < 100; n++) send_matrix(rand_matrix(), 1'b1);
      calm = 1'b0;
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
    if (errors == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

  initial begin
    #2ms;
    $display("TEST FAILED");
    $finish;
  end

endmodule

`default_nettype wire
